// ===== rtl/frcp_pkg.sv =====
// Shared constants, payload types and the quarter-wave trig table of the chirp rotator.
package frcp_pkg;

  // Image geometry
  localparam int MAX_DIM_LOG2 = 12;
  localparam int LOG2_W       = 4;
  localparam int DIM_W        = MAX_DIM_LOG2;
  localparam int DIST_W       = DIM_W + 1;
  localparam int SQ_W         = 2 * DIM_W;

  // Phase and trig table
  localparam int PHASE_W      = 32;
  localparam int TRIG_LOG2    = 10;
  localparam int QIDX_W       = TRIG_LOG2 - 2;
  localparam int Q_ENT        = 1 << QIDX_W;
  localparam int TRIG_W       = 16;
  localparam int MAG_W        = TRIG_W - 1;
  localparam int FRAC_BITS    = 15;

  // Datapath
  localparam int SAMP_W       = 32;
  localparam int PROD_W       = SAMP_W + TRIG_W;
  localparam int SUM_W        = PROD_W + 1;
  localparam int SHIFT_W      = $clog2(FRAC_BITS + 2 * MAX_DIM_LOG2 + 1);

  localparam logic [63:0] Q30_ONE    = 64'd1073741824;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  // Register map
  typedef enum logic [1:0] {
    CFG_PHASE_STEP = 2'd0,
    CFG_COLS_LOG2  = 2'd1,
    CFG_ROWS_LOG2  = 2'd2
  } cfg_idx_t;

  // Quadrant of the table index
  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_t;

  typedef struct packed {
    logic [LOG2_W-1:0] cl;
    logic [LOG2_W-1:0] rl;
  } dim_cfg_t;

  typedef struct packed {
    logic signed [SAMP_W-1:0] re;
    logic signed [SAMP_W-1:0] im;
  } cplx_t;

  // Geometry stage to trig stage
  typedef struct packed {
    logic [TRIG_LOG2-1:0] idx;
    cplx_t                smp;
  } geom_word_t;

  // Trig stage to rotation stage
  typedef struct packed {
    logic signed [TRIG_W-1:0] cs;
    logic signed [TRIG_W-1:0] sn;
    cplx_t                    smp;
  } trig_word_t;

  typedef struct packed {
    logic [MAG_W-1:0] c_mag;
    logic [MAG_W-1:0] s_mag;
  } trig_ent_t;

  typedef trig_ent_t [Q_ENT-1:0] trig_tab_t;

  // One minus t in Q30, floored at zero
  function automatic logic [63:0] q30_sub(input logic [63:0] t);
    return (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
  endfunction

  // Round Q30 to Q15 magnitude, clamp to full scale
  function automatic logic [MAG_W-1:0] q15_mag(input logic [63:0] v);
    logic [63:0] m;
    m = (v + 64'd16384) >> FRAC_BITS;
    return (m > 64'((1 << MAG_W) - 1)) ? {MAG_W{1'b1}} : m[MAG_W-1:0];
  endfunction

  // Sine and cosine of one in-quadrant step by Horner Taylor series in Q30
  function automatic trig_ent_t trig_calc(input logic [QIDX_W-1:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] a;
    logic [63:0] s;
    logic [63:0] c;
    trig_ent_t   e;
    x  = (64'(r) * TWO_PI_Q30) >> TRIG_LOG2;
    x2 = (x * x) >> 30;

    a = q30_sub(((x2 * Q30_ONE) >> 30) / 64'd156);
    a = q30_sub(((x2 * a) >> 30) / 64'd110);
    a = q30_sub(((x2 * a) >> 30) / 64'd72);
    a = q30_sub(((x2 * a) >> 30) / 64'd42);
    a = q30_sub(((x2 * a) >> 30) / 64'd20);
    a = q30_sub(((x2 * a) >> 30) / 64'd6);
    s = (x * a) >> 30;

    a = q30_sub(((x2 * Q30_ONE) >> 30) / 64'd132);
    a = q30_sub(((x2 * a) >> 30) / 64'd90);
    a = q30_sub(((x2 * a) >> 30) / 64'd56);
    a = q30_sub(((x2 * a) >> 30) / 64'd30);
    a = q30_sub(((x2 * a) >> 30) / 64'd12);
    c = q30_sub(((x2 * a) >> 30) / 64'd2);

    e.c_mag = q15_mag(c);
    e.s_mag = q15_mag(s);
    return e;
  endfunction

  function automatic trig_tab_t build_trig_tab();
    trig_tab_t t;
    for (int i = 0; i < Q_ENT; i++) begin
      t[i] = trig_calc(QIDX_W'(i));
    end
    return t;
  endfunction

  // Quarter-wave magnitudes, worked out at elaboration
  localparam trig_tab_t TRIG_TAB = build_trig_tab();

endpackage

// ===== rtl/frcp_if.sv =====
// Valid/ready channel interfaces for spectrum samples in and rotated samples out.
interface frcp_in_if;
  logic                                  valid;
  logic                                  ready;
  logic        [frcp_pkg::DIM_W-1:0]     col;
  logic        [frcp_pkg::DIM_W-1:0]     row;
  logic signed [frcp_pkg::SAMP_W-1:0]    re_in;
  logic signed [frcp_pkg::SAMP_W-1:0]    im_in;

  modport source (output valid, col, row, re_in, im_in, input ready);
  modport sink   (input valid, col, row, re_in, im_in, output ready);
endinterface

interface frcp_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [frcp_pkg::SAMP_W-1:0]    re_out;
  logic signed [frcp_pkg::SAMP_W-1:0]    im_out;
  logic                                  saturated;

  modport source (output valid, re_out, im_out, saturated, input ready);
  modport sink   (input valid, re_out, im_out, saturated, output ready);
endinterface

// ===== rtl/frcp_geom.sv =====
// Four-stage geometry pipe: centred distances, squares, negated r^2, chirp phase index.
module frcp_geom (
  input  logic                             clk,
  input  logic                             rst_n,
  input  frcp_pkg::dim_cfg_t               dims,
  input  logic [frcp_pkg::PHASE_W-1:0]     phase_step,
  frcp_in_if.sink                          in_chan,
  output logic                             dn_valid,
  input  logic                             dn_ready,
  output frcp_pkg::geom_word_t             dn_word
);
  import frcp_pkg::*;

  localparam int NST = 4;

  logic [NST-1:0] v_r;
  logic [NST-1:0] en;
  logic [NST-1:0] v_prev;

  logic [DIM_W:0]              w_col;
  logic [DIM_W:0]              h_row;
  logic signed [DIST_W-1:0]    dx;
  logic signed [DIST_W-1:0]    dy;
  logic signed [2*DIST_W-1:0]  px;
  logic signed [2*DIST_W-1:0]  py;
  logic [PHASE_W-1:0]          nsq;
  logic [PHASE_W-1:0]          ph;

  logic signed [DIST_W-1:0]    dx_r;
  logic signed [DIST_W-1:0]    dy_r;
  logic [SQ_W-1:0]             sqx_r;
  logic [SQ_W-1:0]             sqy_r;
  logic [PHASE_W-1:0]          nsq_r;
  logic [TRIG_LOG2-1:0]        idx_r;
  cplx_t                       smp_r [NST];

  // Ripple enables back from the sink so bubbles collapse
  always_comb begin
    en[NST-1] = !v_r[NST-1] || dn_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign v_prev        = {v_r[NST-2:0], in_chan.valid};
  assign in_chan.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_prev[k];
        end
      end
    end
  end

  // Wrap position into the image and centre it
  always_comb begin
    w_col = (DIM_W + 1)'(1) << dims.cl;
    h_row = (DIM_W + 1)'(1) << dims.rl;
    dx = $signed({1'b0, in_chan.col & DIM_W'(w_col - 1'b1)})
       - $signed({1'b0, DIM_W'(w_col >> 1)});
    dy = $signed({1'b0, in_chan.row & DIM_W'(h_row - 1'b1)})
       - $signed({1'b0, DIM_W'(h_row >> 1)});
  end

  // Squares, negated squared radius, phase product
  always_comb begin
    px  = dx_r * dx_r;
    py  = dy_r * dy_r;
    nsq = PHASE_W'(0) - (PHASE_W'(sqx_r) + PHASE_W'(sqy_r));
    ph  = phase_step * nsq_r;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx_r      <= dx;
      dy_r      <= dy;
      smp_r[0]  <= '{re: in_chan.re_in, im: in_chan.im_in};
    end
    if (en[1]) begin
      sqx_r     <= SQ_W'($unsigned(px));
      sqy_r     <= SQ_W'($unsigned(py));
      smp_r[1]  <= smp_r[0];
    end
    if (en[2]) begin
      nsq_r     <= nsq;
      smp_r[2]  <= smp_r[1];
    end
    if (en[3]) begin
      idx_r     <= ph[PHASE_W-1 -: TRIG_LOG2];
      smp_r[3]  <= smp_r[2];
    end
  end

  assign dn_valid    = v_r[NST-1];
  assign dn_word.idx = idx_r;
  assign dn_word.smp = smp_r[NST-1];

endmodule

// ===== rtl/frcp_trig.sv =====
// Trig stage: quarter-wave table read and quadrant sign folding.
module frcp_trig (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  frcp_pkg::geom_word_t  up_word,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output frcp_pkg::trig_word_t  dn_word
);
  import frcp_pkg::*;

  logic                     v_r;
  logic                     en;
  quad_t                    quad;
  trig_ent_t                ent;
  logic signed [TRIG_W-1:0] c_pos;
  logic signed [TRIG_W-1:0] s_pos;
  logic signed [TRIG_W-1:0] cs;
  logic signed [TRIG_W-1:0] sn;
  trig_word_t               word_r;

  assign en       = !v_r || dn_ready;
  assign up_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= up_valid;
    end
  end

  // Look up in-quadrant magnitudes and rotate them into place
  always_comb begin
    quad  = quad_t'(up_word.idx[TRIG_LOG2-1 -: 2]);
    ent   = TRIG_TAB[up_word.idx[QIDX_W-1:0]];
    c_pos = $signed({1'b0, ent.c_mag});
    s_pos = $signed({1'b0, ent.s_mag});
    case (quad)
      QUAD_I: begin
        cs = c_pos;
        sn = s_pos;
      end
      QUAD_II: begin
        cs = -s_pos;
        sn = c_pos;
      end
      QUAD_III: begin
        cs = -c_pos;
        sn = -s_pos;
      end
      default: begin
        cs = s_pos;
        sn = -c_pos;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r.cs  <= cs;
      word_r.sn  <= sn;
      word_r.smp <= up_word.smp;
    end
  end

  assign dn_valid = v_r;
  assign dn_word  = word_r;

endmodule

// ===== rtl/frcp_rot.sv =====
// Three-stage rotation pipe: complex products, sums, scaling shift with saturation.
module frcp_rot (
  input  logic                  clk,
  input  logic                  rst_n,
  input  frcp_pkg::dim_cfg_t    dims,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  frcp_pkg::trig_word_t  up_word,
  frcp_out_if.source            out_chan
);
  import frcp_pkg::*;

  localparam int NST = 3;
  localparam logic signed [SAMP_W-1:0] SAT_MAX = {1'b0, {(SAMP_W-1){1'b1}}};
  localparam logic signed [SAMP_W-1:0] SAT_MIN = {1'b1, {(SAMP_W-1){1'b0}}};

  logic [NST-1:0] v_r;
  logic [NST-1:0] en;
  logic [NST-1:0] v_prev;

  logic signed [PROD_W-1:0] p_rc;
  logic signed [PROD_W-1:0] p_is;
  logic signed [PROD_W-1:0] p_rs;
  logic signed [PROD_W-1:0] p_ic;
  logic signed [SUM_W-1:0]  sum_re;
  logic signed [SUM_W-1:0]  sum_im;
  logic [SHIFT_W-1:0]       sh;
  logic signed [SUM_W-1:0]  shr_re;
  logic signed [SUM_W-1:0]  shr_im;
  logic                     ovf_re;
  logic                     ovf_im;
  logic signed [SAMP_W-1:0] re_sat;
  logic signed [SAMP_W-1:0] im_sat;

  logic signed [PROD_W-1:0] p_rc_r;
  logic signed [PROD_W-1:0] p_is_r;
  logic signed [PROD_W-1:0] p_rs_r;
  logic signed [PROD_W-1:0] p_ic_r;
  logic signed [SUM_W-1:0]  sum_re_r;
  logic signed [SUM_W-1:0]  sum_im_r;
  logic signed [SAMP_W-1:0] re_r;
  logic signed [SAMP_W-1:0] im_r;
  logic                     sat_r;

  // Ripple enables back from the output register
  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_chan.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign v_prev   = {v_r[NST-2:0], up_valid};
  assign up_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_prev[k];
        end
      end
    end
  end

  // Products, sums, floor shift by 15 + log2(W*H), clip to word width
  always_comb begin
    p_rc   = up_word.smp.re * up_word.cs;
    p_is   = up_word.smp.im * up_word.sn;
    p_rs   = up_word.smp.re * up_word.sn;
    p_ic   = up_word.smp.im * up_word.cs;
    sum_re = p_rc_r - p_is_r;
    sum_im = p_rs_r + p_ic_r;
    sh     = SHIFT_W'(FRAC_BITS) + SHIFT_W'(dims.cl) + SHIFT_W'(dims.rl);
    shr_re = sum_re_r >>> sh;
    shr_im = sum_im_r >>> sh;
    ovf_re = shr_re[SUM_W-1:SAMP_W-1] != {(SUM_W-SAMP_W+1){shr_re[SUM_W-1]}};
    ovf_im = shr_im[SUM_W-1:SAMP_W-1] != {(SUM_W-SAMP_W+1){shr_im[SUM_W-1]}};
    re_sat = ovf_re ? (shr_re[SUM_W-1] ? SAT_MIN : SAT_MAX) : shr_re[SAMP_W-1:0];
    im_sat = ovf_im ? (shr_im[SUM_W-1] ? SAT_MIN : SAT_MAX) : shr_im[SAMP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_rc_r   <= p_rc;
      p_is_r   <= p_is;
      p_rs_r   <= p_rs;
      p_ic_r   <= p_ic;
    end
    if (en[1]) begin
      sum_re_r <= sum_re;
      sum_im_r <= sum_im;
    end
    if (en[2]) begin
      re_r     <= re_sat;
      im_r     <= im_sat;
      sat_r    <= ovf_re || ovf_im;
    end
  end

  assign out_chan.valid     = v_r[NST-1];
  assign out_chan.re_out    = re_r;
  assign out_chan.im_out    = im_r;
  assign out_chan.saturated = sat_r;

endmodule

// ===== rtl/fresnel_chirp_phase_rotator.sv =====
// Top level of the Fresnel chirp phase rotator: config registers and the stage chain.
//
//   channel   dir  fields                           word
//   in_chan   in   col, row, re_in, im_in           one spectrum sample
//   out_chan  out  re_out, im_out, saturated        one rotated, scaled sample
//   cfg_*     in   cfg_we, cfg_idx, cfg_wdata       one register write
//
// One word per cycle when the output is not stalled; an accepted word passes through
// four geometry stages, one trig table stage and three rotation stages before it sits
// in the output register.
// Reset clears all stage valid bits and loads phase_step 0, both log2 sizes 8.
// A stall at the output backs up stage by stage; empty stages keep taking words.
module fresnel_chirp_phase_rotator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_idx,
  input  logic [frcp_pkg::PHASE_W-1:0]   cfg_wdata,
  frcp_in_if.sink                        in_chan,
  frcp_out_if.source                     out_chan
);
  import frcp_pkg::*;

  logic [PHASE_W-1:0] phase_step_r;
  logic [LOG2_W-1:0]  cols_log2_r;
  logic [LOG2_W-1:0]  rows_log2_r;
  dim_cfg_t           dims;

  logic       g_valid;
  logic       g_ready;
  geom_word_t g_word;
  logic       t_valid;
  logic       t_ready;
  trig_word_t t_word;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= '0;
      cols_log2_r  <= LOG2_W'(8);
      rows_log2_r  <= LOG2_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_PHASE_STEP: phase_step_r <= cfg_wdata;
        CFG_COLS_LOG2:  cols_log2_r  <= cfg_wdata[LOG2_W-1:0];
        CFG_ROWS_LOG2:  rows_log2_r  <= cfg_wdata[LOG2_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp sizes into 1 .. MAX_DIM_LOG2
  always_comb begin
    dims.cl = (cols_log2_r == '0) ? LOG2_W'(1) :
              (cols_log2_r > LOG2_W'(MAX_DIM_LOG2)) ? LOG2_W'(MAX_DIM_LOG2) : cols_log2_r;
    dims.rl = (rows_log2_r == '0) ? LOG2_W'(1) :
              (rows_log2_r > LOG2_W'(MAX_DIM_LOG2)) ? LOG2_W'(MAX_DIM_LOG2) : rows_log2_r;
  end

  frcp_geom u_geom (
    .clk        (clk),
    .rst_n      (rst_n),
    .dims       (dims),
    .phase_step (phase_step_r),
    .in_chan    (in_chan),
    .dn_valid   (g_valid),
    .dn_ready   (g_ready),
    .dn_word    (g_word)
  );

  frcp_trig u_trig (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (g_valid),
    .up_ready (g_ready),
    .up_word  (g_word),
    .dn_valid (t_valid),
    .dn_ready (t_ready),
    .dn_word  (t_word)
  );

  frcp_rot u_rot (
    .clk      (clk),
    .rst_n    (rst_n),
    .dims     (dims),
    .up_valid (t_valid),
    .up_ready (t_ready),
    .up_word  (t_word),
    .out_chan (out_chan)
  );

`ifndef NO_ASSERTIONS
  // An empty output register lets the whole chain move
  a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !out_chan.valid |-> in_chan.ready)
    else $error("input stalled with empty output register");

  // The scaling shift is always wide enough that no clip occurs
  a_no_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> !out_chan.saturated)
    else $error("unexpected saturation");

  // A width write lands in its register
  a_cols_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_idx == CFG_COLS_LOG2) |=> cols_log2_r == $past(cfg_wdata[LOG2_W-1:0]))
    else $error("cols_log2 write lost");
`endif

endmodule

// ===== tb/tb_fresnel_chirp_phase_rotator.sv =====
// Self-checking testbench for the Fresnel chirp phase rotator: directed and random samples.
`timescale 1ns / 1ps

module tb_fresnel_chirp_phase_rotator;
  import frcp_pkg::*;

  localparam int LATENCY = 8;
  localparam logic [63:0] ONE_Q30  = 64'd1073741824;
  localparam logic [63:0] TURN_Q30 = 64'd6746518852;

  typedef struct {
    logic signed [SAMP_W-1:0] re;
    logic signed [SAMP_W-1:0] im;
    logic                     sat;
  } rot_word_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_idx;
  logic [PHASE_W-1:0] cfg_wdata;

  frcp_in_if  in_if ();
  frcp_out_if out_if ();

  fresnel_chirp_phase_rotator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_if),
    .out_chan  (out_if)
  );

  // Register mirror
  logic [PHASE_W-1:0] step_reg;
  logic [3:0]         cols_reg;
  logic [3:0]         rows_reg;

  rot_word_t expected_rot_q[$];
  int        fail_count = 0;
  int        burst_left;

  // Clock: 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // One Horner step: one minus (x2*acc >> 30) / d, floored at zero
  function automatic logic [63:0] taylor_term(input logic [63:0] acc, input logic [63:0] x2,
                                              input logic [63:0] d);
    logic [63:0] t;
    t = ((x2 * acc) >> 30) / d;
    return (t >= ONE_Q30) ? 64'd0 : ONE_Q30 - t;
  endfunction

  // Round Q30 magnitude to Q15, clamp, apply sign
  function automatic logic signed [TRIG_W-1:0] round_q15(input logic [63:0] v, input logic neg);
    logic [63:0] m;
    m = (v + 64'd16384) >> 15;
    if (m > 64'd32767) m = 64'd32767;
    return neg ? -$signed(m[TRIG_W-1:0]) : $signed(m[TRIG_W-1:0]);
  endfunction

  // Cosine and sine of table entry k
  task automatic chirp_trig(input logic [TRIG_LOG2-1:0] k,
                            output logic signed [TRIG_W-1:0] cs,
                            output logic signed [TRIG_W-1:0] sn);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] a;
    logic [63:0] s;
    logic [63:0] c;
    quad_t       q;
    q  = quad_t'(k[TRIG_LOG2-1 -: 2]);
    x  = (64'(k[QIDX_W-1:0]) * TURN_Q30) >> TRIG_LOG2;
    x2 = (x * x) >> 30;

    a = taylor_term(ONE_Q30, x2, 64'd156);
    a = taylor_term(a, x2, 64'd110);
    a = taylor_term(a, x2, 64'd72);
    a = taylor_term(a, x2, 64'd42);
    a = taylor_term(a, x2, 64'd20);
    a = taylor_term(a, x2, 64'd6);
    s = (x * a) >> 30;

    a = taylor_term(ONE_Q30, x2, 64'd132);
    a = taylor_term(a, x2, 64'd90);
    a = taylor_term(a, x2, 64'd56);
    a = taylor_term(a, x2, 64'd30);
    a = taylor_term(a, x2, 64'd12);
    c = taylor_term(a, x2, 64'd2);

    case (q)
      QUAD_I: begin
        cs = round_q15(c, 1'b0);
        sn = round_q15(s, 1'b0);
      end
      QUAD_II: begin
        cs = round_q15(s, 1'b1);
        sn = round_q15(c, 1'b0);
      end
      QUAD_III: begin
        cs = round_q15(c, 1'b1);
        sn = round_q15(s, 1'b1);
      end
      default: begin
        cs = round_q15(s, 1'b0);
        sn = round_q15(c, 1'b1);
      end
    endcase
  endtask

  // Saturate a shifted sum to 32 bits
  function automatic logic signed [SAMP_W-1:0] clip32(input logic signed [63:0] v,
                                                      inout logic clipped);
    if (v > 64'sd2147483647) begin
      clipped = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1'b1;
      return 32'sh80000000;
    end
    return v[SAMP_W-1:0];
  endfunction

  // Expected rotated, scaled sample for the current register settings
  task automatic predict_rotation(input logic [DIM_W-1:0] col, input logic [DIM_W-1:0] row,
                                  input logic signed [SAMP_W-1:0] re,
                                  input logic signed [SAMP_W-1:0] im,
                                  output rot_word_t res);
    int cl;
    int rl;
    int w;
    int h;
    int dx;
    int dy;
    logic [31:0] sq;
    logic [31:0] ph;
    logic signed [TRIG_W-1:0] cs;
    logic signed [TRIG_W-1:0] sn;
    logic signed [63:0] pr;
    logic signed [63:0] pq;
    logic clipped;
    cl = (cols_reg < 1) ? 1 : (cols_reg > MAX_DIM_LOG2) ? MAX_DIM_LOG2 : int'(cols_reg);
    rl = (rows_reg < 1) ? 1 : (rows_reg > MAX_DIM_LOG2) ? MAX_DIM_LOG2 : int'(rows_reg);
    w  = 1 << cl;
    h  = 1 << rl;
    dx = int'(col) % w - w / 2;
    dy = int'(row) % h - h / 2;
    sq = 32'(dx * dx + dy * dy);
    ph = step_reg * sq;
    ph = -ph;
    chirp_trig(ph[31 -: TRIG_LOG2], cs, sn);
    pr = 64'(re) * 64'(cs) - 64'(im) * 64'(sn);
    pq = 64'(re) * 64'(sn) + 64'(im) * 64'(cs);
    clipped = 1'b0;
    res.re  = clip32(pr >>> (15 + cl + rl), clipped);
    res.im  = clip32(pq >>> (15 + cl + rl), clipped);
    res.sat = clipped;
  endtask

  // Write one register; the mirror follows at the same edge
  task automatic write_reg(input cfg_idx_t idx, input logic [PHASE_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_PHASE_STEP: step_reg = data;
      CFG_COLS_LOG2:  cols_reg = data[3:0];
      CFG_ROWS_LOG2:  rows_reg = data[3:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(input logic [PHASE_W-1:0] step, input logic [3:0] cl,
                              input logic [3:0] rl);
    write_reg(CFG_PHASE_STEP, step);
    write_reg(CFG_COLS_LOG2, {$urandom_range(0, 1) ? 28'($urandom) : 28'd0, cl});
    write_reg(CFG_ROWS_LOG2, {$urandom_range(0, 1) ? 28'($urandom) : 28'd0, rl});
  endtask

  // Send one word in bursts with random gaps; record its expectation on accept
  task automatic send_sample(input logic [DIM_W-1:0] col, input logic [DIM_W-1:0] row,
                             input logic signed [SAMP_W-1:0] re,
                             input logic signed [SAMP_W-1:0] im);
    int gap;
    rot_word_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        in_if.col   <= DIM_W'($urandom);
        in_if.re_in <= $urandom;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.col   <= col;
    in_if.row   <= row;
    in_if.re_in <= re;
    in_if.im_in <= im;
    do @(posedge clk); while (!in_if.ready);
    predict_rotation(col, row, re, im, res);
    expected_rot_q.push_back(res);
  endtask

  // Hold off until every expected word has come back
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (expected_rot_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic logic signed [SAMP_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(0, 255))) - 32'sd128;
      default: return $urandom;
    endcase
  endfunction

  // Reset values: zero phase, 256 x 256
  task automatic test_reset_defaults();
    send_sample(12'd0, 12'd0, 32'sh7FFFFFFF, 32'sh80000000);
    send_sample(12'd128, 12'd128, 32'sh80000000, 32'sh7FFFFFFF);
    send_sample(12'hFFF, 12'h0A5, 32'sd12345678, -32'sd87654321);
    drain_results();
  endtask

  // Largest image, largest step, corner and center positions, full-scale values
  task automatic test_extremes();
    set_geometry(32'hFFFFFFFF, 4'd12, 4'd12);
    send_sample(12'd0, 12'd0, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_sample(12'hFFF, 12'hFFF, 32'sh80000000, 32'sh80000000);
    send_sample(12'd2048, 12'd2048, 32'sh7FFFFFFF, 32'sh80000000);
    send_sample(12'd0, 12'hFFF, 32'sh80000000, 32'sh7FFFFFFF);
    send_sample(12'hAAA, 12'h555, 32'shAAAAAAAA, 32'sh55555555);
    send_sample(12'h555, 12'hAAA, 32'sh55555555, 32'shAAAAAAAA);
    drain_results();
  endtask

  // Table entries at and around each quadrant boundary (dx 1, dy 0)
  task automatic test_quadrants();
    int ks[8] = '{0, 1, 255, 256, 511, 512, 768, 1023};
    foreach (ks[i]) begin
      set_geometry(32'((1024 - ks[i]) % 1024) << 22, 4'd4, 4'd4);
      send_sample(12'd9, 12'd8, 32'sd1048576, -32'sd524288);
      drain_results();
    end
  endtask

  // Size registers out of range and positions beyond the image
  task automatic test_dim_clamp();
    set_geometry(32'h01234567, 4'd0, 4'd15);
    send_sample(12'hFFF, 12'hFFF, 32'sh7FFFFFFF, -32'sd1);
    send_sample(12'd3, 12'd4095, 32'sd1000000, 32'sd2000000);
    drain_results();
    set_geometry(32'h89ABCDEF, 4'd13, 4'd1);
    send_sample(12'd2049, 12'd7, 32'sh80000000, 32'sd77);
    send_sample(12'd4000, 12'd2, -32'sd5, 32'sh7FFFFFFF);
    drain_results();
    set_geometry(32'h00400000, 4'd1, 4'd1);
    send_sample(12'd1, 12'd0, 32'sh40000000, 32'shC0000000);
    send_sample(12'd2, 12'd3, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    drain_results();
  endtask

  // Random phases: new settings per phase, random samples, one mid-phase hold-off
  task automatic test_random();
    logic [PHASE_W-1:0] step;
    logic [3:0] cl;
    logic [3:0] rl;
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] row;
    int n;
    for (int p = 0; p < 10; p++) begin
      case ($urandom_range(0, 4))
        0: step = 32'hFFFFFFFF;
        1: step = 32'($urandom_range(0, 1023)) << 22;
        2: step = 32'($urandom_range(0, 255));
        default: step = $urandom;
      endcase
      case (p)
        0: begin cl = 4'd1;  rl = 4'd1;  end
        1: begin cl = 4'd12; rl = 4'd12; end
        2: begin cl = 4'd0;  rl = 4'd15; end
        default: begin
          cl = 4'($urandom_range(0, 15));
          rl = 4'($urandom_range(0, 15));
        end
      endcase
      set_geometry(step, cl, rl);
      n = $urandom_range(40, 60);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 1)) begin
          col = DIM_W'($urandom);
          row = DIM_W'($urandom);
        end else begin
          col = DIM_W'($urandom_range(0, 4095)) & DIM_W'((1 << (cl < 1 ? 1 : cl)) - 1);
          row = DIM_W'($urandom_range(0, 4095)) & DIM_W'((1 << (rl < 1 ? 1 : rl)) - 1);
        end
        send_sample(col, row, rand_sample(), rand_sample());
        if (p == 4 && i == n / 2) drain_results();
      end
      drain_results();
    end
  endtask

  // Receiver: stall pattern and result check
  int stall_mode = 0;
  int stall_left = 0;
  int stall_phase = 0;

  always @(posedge clk) begin
    rot_word_t exp_w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_rot_q.size() == 0) begin
        $error("unexpected word: re_out %0d im_out %0d", out_if.re_out, out_if.im_out);
        fail_count++;
      end else begin
        exp_w = expected_rot_q.pop_front();
        if (out_if.re_out !== exp_w.re) begin
          $error("re_out: expected %0d actual %0d", exp_w.re, out_if.re_out);
          fail_count++;
        end
        if (out_if.im_out !== exp_w.im) begin
          $error("im_out: expected %0d actual %0d", exp_w.im, out_if.im_out);
          fail_count++;
        end
        if (out_if.saturated !== exp_w.sat) begin
          $error("saturated: expected %0b actual %0b", exp_w.sat, out_if.saturated);
          fail_count++;
        end
      end
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 80);
    end else begin
      stall_left--;
    end
    stall_phase++;
    case (stall_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= 1'($urandom_range(0, 1));
      2: out_if.ready <= (stall_phase % 4 == 0);
      default: out_if.ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // Time limit
  initial begin
    #2ms;
    $display("tb_fresnel_chirp_phase_rotator NOT OK");
    $finish;
  end

  // Main sequence
  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_PHASE_STEP;
    cfg_wdata     = '0;
    in_if.valid   = 1'b0;
    in_if.col     = '0;
    in_if.row     = '0;
    in_if.re_in   = '0;
    in_if.im_in   = '0;
    step_reg      = 32'd0;
    cols_reg      = 4'd8;
    rows_reg      = 4'd8;
    burst_left    = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_extremes();
    test_quadrants();
    test_dim_clamp();
    test_random();

    drain_results();
    repeat (4 * LATENCY) @(posedge clk);
    if (fail_count == 0 && expected_rot_q.size() == 0) begin
      $display("tb_fresnel_chirp_phase_rotator OK");
    end else begin
      $display("tb_fresnel_chirp_phase_rotator NOT OK");
    end
    $finish;
  end

endmodule
